// ----- hw/rtl/chsq_pkg.sv -----
// Shared types and constants for the convex hull support query block.
// Holds field widths, opcode and result-kind codes, and the walk control struct.
// No dependencies.
package chsq_pkg;

    localparam int CFG_WIDTH   = 7;
    localparam int SLOT_WIDTH  = 6;
    localparam int OP_WIDTH    = 2;
    localparam int KIND_WIDTH  = 2;
    localparam int INDEX_WIDTH = 6;

    localparam logic [OP_WIDTH-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUPPORT = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_BBOX    = 2'd2;

    localparam logic [KIND_WIDTH-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SUPPORT = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_CORNER  = 2'd2;

    // Sequencer to walk datapath: one vertex read issued this cycle.
    typedef struct packed {
        logic issue;
        logic first;
    } t_walk_ctl;

endpackage

// ----- hw/rtl/chsq_vstore.sv -----
// Vertex store: single-port-write, registered-read memory plus the clearing sweep
// run after reset and after a shrinking count write. No package dependency.
module chsq_vstore #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16,
    localparam int AW   = $clog2(MAX_VERTICES),
    localparam int CNTW = AW + 1,
    localparam int VW   = 3 * COORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CNTW-1:0] i_new_count,
    input  logic [CNTW-1:0] i_active,
    output logic            o_clearing,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  logic [VW-1:0]   i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output logic [VW-1:0]   o_rdata
);

    logic [VW-1:0]   mem [MAX_VERTICES];
    logic [VW-1:0]   r_rdata;
    logic            r_clr;
    logic [CNTW-1:0] r_ptr;
    logic [CNTW-1:0] r_end;

    logic            clr_hit;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [VW-1:0]   mem_wdata;
    logic [CNTW-1:0] ptr_inc;

    // The sweep only ever spans entries that must read as zero, so each one is cleared.
    assign clr_hit = r_clr;
    assign ptr_inc = r_ptr + CNTW'(1);

    always_comb begin
        mem_we    = clr_hit || i_we;
        mem_addr  = r_clr ? r_ptr[AW-1:0] : i_waddr;
        mem_wdata = r_clr ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_ptr  <= '0;
            r_end  <= CNTW'(MAX_VERTICES);
        end else if (i_cfg_we) begin
            if (r_clr) begin
                // merge with the sweep in flight
                if (i_new_count < r_ptr) begin
                    r_ptr <= i_new_count;
                end
                if (i_active > r_end) begin
                    r_end <= i_active;
                end
            end else if (i_new_count < i_active) begin
                r_clr <= 1'b1;
                r_ptr <= i_new_count;
                r_end <= i_active;
            end
        end else if (r_clr) begin
            r_ptr <= ptr_inc;
            if (ptr_inc == r_end) begin
                r_clr  <= 1'b0;
            end
        end
    end

    assign o_clearing = r_clr;
    assign o_rdata    = r_rdata;

endmodule

// ----- hw/rtl/chsq_walk.sv -----
// Walk datapath: dot product and per-axis min/max, one vertex per cycle, with
// running best/lo/hi accumulators. Depends on chsq_pkg (t_walk_ctl).
module chsq_walk
    import chsq_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int CW = COORD_WIDTH,
    localparam int VW = 3 * COORD_WIDTH,
    localparam int PW = 2 * COORD_WIDTH,
    localparam int SW = 2 * COORD_WIDTH + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_walk_ctl            i_ctl,
    input  logic [AW-1:0]        i_idx,
    input  logic signed [CW-1:0] i_dir_x,
    input  logic signed [CW-1:0] i_dir_y,
    input  logic signed [CW-1:0] i_dir_z,
    input  logic [VW-1:0]        i_rdata,
    output logic                 o_busy,
    output logic signed [SW-1:0] o_best_val,
    output logic [VW-1:0]        o_best_vtx,
    output logic [AW-1:0]        o_best_idx,
    output logic [VW-1:0]        o_lo,
    output logic [VW-1:0]        o_hi
);

    // tag aligned with the registered read data
    logic          r_t0_v;
    logic          r_t0_first;
    logic [AW-1:0] r_t0_idx;

    logic                 r_s1_v;
    logic                 r_s1_first;
    logic [AW-1:0]        r_s1_idx;
    logic [VW-1:0]        r_s1_vtx;
    logic signed [PW-1:0] r_s1_p0;
    logic signed [PW-1:0] r_s1_p1;
    logic signed [PW-1:0] r_s1_p2;

    logic                 r_s2_v;
    logic                 r_s2_first;
    logic [AW-1:0]        r_s2_idx;
    logic [VW-1:0]        r_s2_vtx;
    logic signed [SW-1:0] r_s2_dot;

    logic signed [SW-1:0] r_best_val;
    logic [VW-1:0]        r_best_vtx;
    logic [AW-1:0]        r_best_idx;
    logic [VW-1:0]        r_lo;
    logic [VW-1:0]        r_hi;
    logic [VW-1:0]        n_lo;
    logic [VW-1:0]        n_hi;

    logic signed [CW-1:0] rd_x, rd_y, rd_z;

    assign rd_x = $signed(i_rdata[0*CW +: CW]);
    assign rd_y = $signed(i_rdata[1*CW +: CW]);
    assign rd_z = $signed(i_rdata[2*CW +: CW]);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        for (int a = 0; a < 3; a++) begin
            if (r_s2_first || ($signed(r_s2_vtx[a*CW +: CW]) < $signed(r_lo[a*CW +: CW]))) begin
                n_lo[a*CW +: CW] = r_s2_vtx[a*CW +: CW];
            end
            if (r_s2_first || ($signed(r_s2_vtx[a*CW +: CW]) > $signed(r_hi[a*CW +: CW]))) begin
                n_hi[a*CW +: CW] = r_s2_vtx[a*CW +: CW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_t0_v <= i_ctl.issue;
            r_s1_v <= r_t0_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0_first <= i_ctl.first;
        r_t0_idx   <= i_idx;

        r_s1_first <= r_t0_first;
        r_s1_idx   <= r_t0_idx;
        r_s1_vtx   <= i_rdata;
        r_s1_p0    <= rd_x * i_dir_x;
        r_s1_p1    <= rd_y * i_dir_y;
        r_s1_p2    <= rd_z * i_dir_z;

        r_s2_first <= r_s1_first;
        r_s2_idx   <= r_s1_idx;
        r_s2_vtx   <= r_s1_vtx;
        r_s2_dot   <= SW'(r_s1_p0) + SW'(r_s1_p1) + SW'(r_s1_p2);

        if (r_s2_v) begin
            // strict compare: the lowest index keeps a tie
            if (r_s2_first || (r_s2_dot > r_best_val)) begin
                r_best_val <= r_s2_dot;
                r_best_vtx <= r_s2_vtx;
                r_best_idx <= r_s2_idx;
            end
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_busy     = r_t0_v || r_s1_v || r_s2_v;
    assign o_best_val = r_best_val;
    assign o_best_vtx = r_best_vtx;
    assign o_best_idx = r_best_idx;
    assign o_lo       = r_lo;
    assign o_hi       = r_hi;

endmodule

// ----- hw/rtl/convex_hull_support_query.sv -----
// Convex hull support query block: top level with the sequencer and output register.
// Depends on chsq_pkg, chsq_vstore and chsq_walk.
//
// Input channel (i_valid / o_stall) takes one transaction per item: opcode, slot and
// three signed Q8.8 coordinates. Output channel (o_valid / i_stall) gives the results.
// A write stores the vertex when its slot lies inside the active count and gives one
// acknowledge transaction via S_EMIT and the output register. A support query walks
// the active vertices through the vertex memory read port, one vertex per cycle into a
// shared dot-product and compare pipeline, and gives one transaction. A bounding-box
// query takes the same walk and gives the minimum corner (last low) then the maximum
// corner (last high). Opcode 3 is taken and dropped. One item is in work at a time;
// the next is taken once the last result has been loaded into the output register,
// even while that result waits.
// A stalled receiver holds the output register, and with it the sequencer.
// After reset the memory is zeroed by a sweep over all MAX_VERTICES entries, o_stall high.
// A vertex count write that shrinks the table zeroes the entries it drops, one per
// cycle while no further count write arrives, with o_stall high meanwhile.
module convex_hull_support_query
    import chsq_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [OP_WIDTH-1:0]           i_opcode,
    input  logic [SLOT_WIDTH-1:0]         i_slot,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [KIND_WIDTH-1:0]         o_kind,
    output logic signed [2*COORD_WIDTH:0] o_support_value,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [INDEX_WIDTH-1:0]        o_winner_index,
    output logic                          o_last
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = AW + 1;
    localparam int CMPW = CNTW + CFG_WIDTH;   // room for count, config and slot
    localparam int CW   = COORD_WIDTH;
    localparam int VW   = 3 * COORD_WIDTH;
    localparam int SW   = 2 * COORD_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_EMIT,
        S_EMIT2
    } t_state;

    t_state               r_state;
    logic [OP_WIDTH-1:0]  r_op;
    logic signed [CW-1:0] r_dir_x, r_dir_y, r_dir_z;
    logic [CNTW-1:0]      r_k;
    logic [CNTW-1:0]      r_active;
    logic [CNTW-1:0]      n_active;

    // output register
    logic                  r_ov;
    logic [KIND_WIDTH-1:0] r_kind;
    logic signed [SW-1:0]  r_sv;
    logic signed [CW-1:0]  r_ox, r_oy, r_oz;
    logic [INDEX_WIDTH-1:0] r_wi;
    logic                  r_last;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 slot_ok;
    logic                 clearing;
    logic [CMPW-1:0]      cfg_ext;
    logic [CNTW-1:0]      k_inc;
    t_walk_ctl            walk_ctl;
    logic                 walk_busy;
    logic [VW-1:0]        rdata;
    logic signed [SW-1:0] best_val;
    logic [VW-1:0]        best_vtx;
    logic [AW-1:0]        best_idx;
    logic [VW-1:0]        lo_vtx;
    logic [VW-1:0]        hi_vtx;

    // Count clamp: zero acts as one, anything above the table size as the size.
    always_comb begin
        cfg_ext = CMPW'(i_cfg_data);
        if (cfg_ext == '0) begin
            n_active = CNTW'(1);
        end else if (cfg_ext > CMPW'(MAX_VERTICES)) begin
            n_active = CNTW'(MAX_VERTICES);
        end else begin
            n_active = CNTW'(cfg_ext);
        end
    end

    assign o_stall  = (r_state != S_IDLE) || clearing || i_cfg_we;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign out_load = out_free && ((r_state == S_EMIT) || (r_state == S_EMIT2));
    assign slot_ok  = CMPW'(i_slot) < CMPW'(r_active);
    assign k_inc    = r_k + CNTW'(1);

    always_comb begin
        walk_ctl.issue = (r_state == S_WALK);
        walk_ctl.first = (r_k == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CNTW'(1);
        end else if (i_cfg_we) begin
            r_active <= n_active;
        end
    end

    chsq_vstore #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_vstore (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_new_count (n_active),
        .i_active    (r_active),
        .o_clearing  (clearing),
        .i_we        (accept && (i_opcode == OP_WRITE) && slot_ok),
        .i_waddr     (AW'(i_slot)),
        .i_wdata     ({i_coord_z, i_coord_y, i_coord_x}),
        .i_re        (walk_ctl.issue),
        .i_raddr     (r_k[AW-1:0]),
        .o_rdata     (rdata)
    );

    chsq_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (walk_ctl),
        .i_idx      (r_k[AW-1:0]),
        .i_dir_x    (r_dir_x),
        .i_dir_y    (r_dir_y),
        .i_dir_z    (r_dir_z),
        .i_rdata    (rdata),
        .o_busy     (walk_busy),
        .o_best_val (best_val),
        .o_best_vtx (best_vtx),
        .o_best_idx (best_idx),
        .o_lo       (lo_vtx),
        .o_hi       (hi_vtx)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // a new result replaces one taken this cycle
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_opcode) inside
                            OP_WRITE:            r_state <= S_EMIT;
                            OP_SUPPORT, OP_BBOX: r_state <= S_WALK;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (k_inc == r_active) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!walk_busy) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= (r_op == OP_BBOX) ? S_EMIT2 : S_IDLE;
                    end
                end
                S_EMIT2: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload side of the sequencer; no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_op    <= i_opcode;
            r_dir_x <= i_coord_x;
            r_dir_y <= i_coord_y;
            r_dir_z <= i_coord_z;
            r_k     <= '0;
        end
        if (r_state == S_WALK) begin
            r_k <= k_inc;
        end
        if (r_state == S_EMIT && out_free) begin
            case (r_op)
                OP_SUPPORT: begin
                    r_kind <= KIND_SUPPORT;
                    r_sv   <= best_val;
                    r_ox   <= $signed(best_vtx[0*CW +: CW]);
                    r_oy   <= $signed(best_vtx[1*CW +: CW]);
                    r_oz   <= $signed(best_vtx[2*CW +: CW]);
                    r_wi   <= INDEX_WIDTH'(best_idx);
                    r_last <= 1'b1;
                end
                OP_BBOX: begin
                    // minimum corner first
                    r_kind <= KIND_CORNER;
                    r_sv   <= '0;
                    r_ox   <= $signed(lo_vtx[0*CW +: CW]);
                    r_oy   <= $signed(lo_vtx[1*CW +: CW]);
                    r_oz   <= $signed(lo_vtx[2*CW +: CW]);
                    r_wi   <= '0;
                    r_last <= 1'b0;
                end
                default: begin
                    r_kind <= KIND_ACK;
                    r_sv   <= '0;
                    r_ox   <= '0;
                    r_oy   <= '0;
                    r_oz   <= '0;
                    r_wi   <= '0;
                    r_last <= 1'b1;
                end
            endcase
        end
        if (r_state == S_EMIT2 && out_free) begin
            r_kind <= KIND_CORNER;
            r_sv   <= '0;
            r_ox   <= $signed(hi_vtx[0*CW +: CW]);
            r_oy   <= $signed(hi_vtx[1*CW +: CW]);
            r_oz   <= $signed(hi_vtx[2*CW +: CW]);
            r_wi   <= '0;
            r_last <= 1'b1;
        end
    end

    assign o_valid         = r_ov;
    assign o_kind          = r_kind;
    assign o_support_value = r_sv;
    assign o_out_x         = r_ox;
    assign o_out_y         = r_oy;
    assign o_out_z         = r_oz;
    assign o_winner_index  = r_wi;
    assign o_last          = r_last;

endmodule
